### rtl/echo_motion_detector_top_defines.svh
// Assertion macros used by the checker file.
`ifndef ECHO_MOTION_DETECTOR_TOP_DEFINES_SVH
`define ECHO_MOTION_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define EMD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define EMD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds through reset.
`define EMD_ASSERT_NXT_NR(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/emd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package emd_pkg;

    localparam int DIST_W      = 18;
    localparam int DIST_MAX    = 131712;
    localparam int ECHO_W      = 16;
    localparam int ECHO_EFF_W  = 15;
    localparam int TIME_W      = 32;
    localparam int QUIET_W     = 16;
    localparam int ECHO_MAX_US = 30000;

    // distance = (echo * 287729 + 2^15) >> 16, i.e. echo * 0.01715 * 256 rounded
    localparam int DIST_MULT   = 287729;
    localparam int DIST_SHIFT  = 16;
    localparam int DIST_ROUND  = 32768;
    localparam int DIST_PROD_W = 35;

    // (4*baseline + distance + 2) / 5 by reciprocal: exact for x < 2^20
    localparam int EMA_W       = 20;
    localparam int DIV5_SH     = 23;
    localparam int DIV5_MUL_W  = 21;
    localparam int DIV5_MUL    = 1677722;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 18;

    localparam logic [DIST_W-1:0]  SENS_RESET  = 18'd2560;
    localparam logic [QUIET_W-1:0] QUIET_RESET = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_SENS   = 2'd1,
        CFG_QUIET  = 2'd2
    } t_cfg_index;

    localparam logic KIND_MEAS = 1'b0;
    localparam logic KIND_READ = 1'b1;

endpackage

`default_nettype wire

### rtl/echo_motion_detector_top.sv
// Channel  Handshake                  Payload
// input    i_valid / o_ready          i_kind, i_echo_us, i_now_ms
// result   o_valid / i_ready          o_distance_q8, o_out_of_range, o_baseline_ready,
//                                     o_baseline_q8, o_motion_flag, o_motion_event
// config   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word per cycle sustained while i_ready is high; each word passes through the stage-one
// registers and then the result register. Stage one holds the distance multiplier, stage two
// the baseline update and its reciprocal dividers; the state loop closes within stage two.
// Reset (i_rst_n low, synchronous) clears state and loads register defaults.
// With i_ready low the result holds and one more word waits in stage one.
// o_cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module echo_motion_detector_top #(
    parameter int INIT_SAMPLES = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_kind,
    input  logic [emd_pkg::ECHO_W-1:0]        i_echo_us,
    input  logic [emd_pkg::TIME_W-1:0]        i_now_ms,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [emd_pkg::DIST_W-1:0]        o_distance_q8,
    output logic                              o_out_of_range,
    output logic                              o_baseline_ready,
    output logic [emd_pkg::DIST_W-1:0]        o_baseline_q8,
    output logic                              o_motion_flag,
    output logic                              o_motion_event,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [emd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [emd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import emd_pkg::*;

    localparam int CNT_W      = $clog2(INIT_SAMPLES + 1);
    localparam int SUM_W      = $clog2(INIT_SAMPLES * DIST_MAX + INIT_SAMPLES / 2 + 1);
    localparam int DIVN_SH    = SUM_W + $clog2(INIT_SAMPLES);
    localparam int DIVN_MUL_W = SUM_W + 2;
    localparam int DIVN_PW    = SUM_W + DIVN_MUL_W;
    localparam logic [63:0] DIVN_MUL64 =
        ((64'd1 << DIVN_SH) + 64'(INIT_SAMPLES) - 64'd1) / 64'(INIT_SAMPLES);
    localparam logic [DIVN_MUL_W-1:0] DIVN_MUL = DIVN_MUL_W'(DIVN_MUL64);
    localparam logic [CNT_W-1:0]      CNT_FULL = CNT_W'(INIT_SAMPLES);
    localparam logic [SUM_W-1:0]      SUM_HALF = SUM_W'(INIT_SAMPLES / 2);
    localparam int DIV5_PW = EMA_W + DIV5_MUL_W;

    // configuration
    logic                r_enable;
    logic [DIST_W-1:0]   r_sens;
    logic [QUIET_W-1:0]  r_quiet;

    // detector state
    logic [DIST_W-1:0]   r_baseline, n_baseline;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_latched, n_latched;
    logic [TIME_W-1:0]   r_last, n_last;

    // stage one
    logic                r_s1_valid;
    logic                r_s1_kind;
    logic [DIST_W-1:0]   r_s1_dist;
    logic                r_s1_oor;
    logic [TIME_W-1:0]   r_s1_now;

    // result register
    logic                r_o_valid;
    logic [DIST_W-1:0]   r_o_dist;
    logic                r_o_oor;
    logic                r_o_ready;
    logic [DIST_W-1:0]   r_o_base;
    logic                r_o_flag;
    logic                r_o_event;

    logic                advance;
    logic                in_acc;
    logic                echo_ok;
    logic                s1_meas;
    logic [ECHO_EFF_W-1:0]  echo_eff;
    logic [DIST_PROD_W-1:0] dist_prod;

    logic [SUM_W-1:0]    sum_add;
    logic [SUM_W-1:0]    sum_rnd;
    logic [DIVN_PW-1:0]  divn_prod;
    logic [DIST_W-1:0]   divn_q;
    logic [EMA_W-1:0]    ema_sum;
    logic [DIV5_PW-1:0]  ema_prod;
    logic [DIST_W-1:0]   ema_q;
    logic [DIST_W-1:0]   delta;
    logic [TIME_W-1:0]   elapsed;
    logic                quiet_done;
    logic [CNT_W-1:0]    cnt_inc;
    logic                flag_out;
    logic                event_out;

    assign advance     = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready     = !r_s1_valid || advance;
    assign in_acc      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // stage one: distance
    assign s1_meas   = (i_kind == KIND_MEAS);
    assign echo_ok   = (i_echo_us != '0) && (i_echo_us <= ECHO_W'(ECHO_MAX_US));
    assign echo_eff  = (s1_meas && echo_ok) ? i_echo_us[ECHO_EFF_W-1:0] : '0;
    assign dist_prod = DIST_PROD_W'(echo_eff) * DIST_PROD_W'(DIST_MULT)
                     + DIST_PROD_W'(DIST_ROUND);

    // stage two: baseline update
    assign sum_add    = r_sum + SUM_W'(r_s1_dist);
    assign sum_rnd    = sum_add + SUM_HALF;
    assign divn_prod  = DIVN_PW'(sum_rnd) * DIVN_PW'(DIVN_MUL);
    assign divn_q     = divn_prod[DIVN_SH +: DIST_W];
    assign ema_sum    = {r_baseline, 2'b00} + EMA_W'(r_s1_dist) + EMA_W'(2);
    assign ema_prod   = DIV5_PW'(ema_sum) * DIV5_PW'(DIV5_MUL);
    assign ema_q      = ema_prod[DIV5_SH +: DIST_W];
    assign delta      = (r_s1_dist >= r_baseline) ? r_s1_dist - r_baseline
                                                  : r_baseline - r_s1_dist;
    assign elapsed    = r_s1_now - r_last;
    assign quiet_done = elapsed >= TIME_W'(r_quiet);
    assign cnt_inc    = r_cnt + CNT_W'(1);

    always_comb begin
        n_baseline = r_baseline;
        n_sum      = r_sum;
        n_cnt      = r_cnt;
        n_latched  = r_latched;
        n_last     = r_last;
        event_out  = 1'b0;
        if (r_s1_kind == KIND_READ) begin
            flag_out  = r_latched;
            n_latched = 1'b0;
        end else begin
            if (r_enable) begin
                if (r_cnt < CNT_FULL) begin
                    n_sum = sum_add;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= CNT_FULL) begin
                        n_baseline = divn_q;
                        n_last     = r_s1_now;
                        n_latched  = 1'b0;
                    end
                end else if (!r_s1_oor) begin
                    if (delta >= r_sens) begin
                        event_out = !r_latched;
                        n_latched = 1'b1;
                        n_last    = r_s1_now;
                    end else begin
                        n_latched = 1'b0;
                        if (quiet_done) begin
                            n_baseline = ema_q;
                            n_last     = r_s1_now;
                        end
                    end
                end
            end
            flag_out = n_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_sens     <= SENS_RESET;
            r_quiet    <= QUIET_RESET;
            r_baseline <= '0;
            r_sum      <= '0;
            r_cnt      <= '0;
            r_latched  <= 1'b0;
            r_last     <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (!r_o_valid || i_ready) begin
                r_o_valid <= r_s1_valid;
            end
            if (advance) begin
                r_baseline <= n_baseline;
                r_sum      <= n_sum;
                r_cnt      <= n_cnt;
                r_latched  <= n_latched;
                r_last     <= n_last;
            end
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_ENABLE: begin
                        r_enable <= i_cfg_data[0];
                        if (i_cfg_data[0] && !r_enable) begin
                            r_baseline <= '0;
                            r_sum      <= '0;
                            r_cnt      <= '0;
                            r_latched  <= 1'b0;
                        end
                    end
                    CFG_SENS: begin
                        r_sens <= i_cfg_data[DIST_W-1:0];
                    end
                    CFG_QUIET: begin
                        r_quiet <= i_cfg_data[QUIET_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind <= i_kind;
            r_s1_dist <= dist_prod[DIST_SHIFT +: DIST_W];
            r_s1_oor  <= s1_meas && !echo_ok;
            r_s1_now  <= i_now_ms;
        end
        if (advance) begin
            r_o_dist  <= r_s1_dist;
            r_o_oor   <= r_s1_oor;
            r_o_ready <= n_cnt >= CNT_FULL;
            r_o_base  <= n_baseline;
            r_o_flag  <= flag_out;
            r_o_event <= event_out;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_distance_q8    = r_o_dist;
    assign o_out_of_range   = r_o_oor;
    assign o_baseline_ready = r_o_ready;
    assign o_baseline_q8    = r_o_base;
    assign o_motion_flag    = r_o_flag;
    assign o_motion_event   = r_o_event;

endmodule

`default_nettype wire

### rtl/emd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "echo_motion_detector_top_defines.svh"

module emd_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic [emd_pkg::DIST_W-1:0]  o_distance_q8,
    input  logic                        o_out_of_range,
    input  logic                        o_baseline_ready,
    input  logic [emd_pkg::DIST_W-1:0]  o_baseline_q8,
    input  logic                        o_motion_flag,
    input  logic                        o_motion_event
);

    `EMD_ASSERT_NXT_NR(a_rst_clears_valid, !i_rst_n, !o_valid)
    `EMD_ASSERT_NXT(a_result_holds, o_valid && !i_ready, o_valid && $stable(o_distance_q8) && $stable(o_baseline_q8) && $stable(o_motion_flag))
    `EMD_ASSERT_IMP(a_event_sets_flag, o_valid && o_motion_event, o_motion_flag)
    `EMD_ASSERT_IMP(a_oor_quiet, o_valid && o_out_of_range, o_distance_q8 == '0 && !o_motion_event)
    `EMD_ASSERT_IMP(a_event_needs_base, o_valid && o_motion_event, o_baseline_ready)

endmodule

bind echo_motion_detector_top emd_checker u_emd_checker (.*);

`default_nettype wire

### test/tb_echo_motion_detector_top.sv
`timescale 1ns / 1ps

module tb_echo_motion_detector_top;
    import emd_pkg::*;

    localparam int WARMUP_SAMPLES = 5;
    localparam int SCALE_MULT     = 287729;
    localparam int ECHO_LIMIT_US  = 30000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              out_of_range;
        logic              base_ready;
        logic [DIST_W-1:0] baseline;
        logic              flag;
        logic              rise;
    } t_reading;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  i_kind      = KIND_MEAS;
    logic [ECHO_W-1:0]     i_echo_us   = '0;
    logic [TIME_W-1:0]     i_now_ms    = '0;
    logic                  i_ready     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_ready;
    logic                  o_valid;
    logic [DIST_W-1:0]     o_distance_q8;
    logic                  o_out_of_range;
    logic                  o_baseline_ready;
    logic [DIST_W-1:0]     o_baseline_q8;
    logic                  o_motion_flag;
    logic                  o_motion_event;
    logic                  o_cfg_ready;

    // predictor state
    logic                  cfg_enable   = 1'b0;
    logic [DIST_W-1:0]     cfg_sens     = SENS_RESET;
    logic [QUIET_W-1:0]    cfg_quiet    = QUIET_RESET;
    logic [DIST_W-1:0]     base_q8      = '0;
    logic [19:0]           warmup_sum   = '0;
    logic [2:0]            warmup_count = '0;
    logic                  motion_held  = 1'b0;
    logic [TIME_W-1:0]     last_move_ms = '0;

    t_reading expected_readings[$];
    int       mismatch_count = 0;
    int       gap_max        = 12;

    echo_motion_detector_top #(
        .INIT_SAMPLES(WARMUP_SAMPLES)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_echo_us       (i_echo_us),
        .i_now_ms        (i_now_ms),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_distance_q8   (o_distance_q8),
        .o_out_of_range  (o_out_of_range),
        .o_baseline_ready(o_baseline_ready),
        .o_baseline_q8   (o_baseline_q8),
        .o_motion_flag   (o_motion_flag),
        .o_motion_event  (o_motion_event),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic void detector_configure(input logic [CFG_IDX_W-1:0] idx,
                                               input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ENABLE: begin
                if (data[0] && !cfg_enable) begin
                    base_q8      = '0;
                    warmup_sum   = '0;
                    warmup_count = '0;
                    motion_held  = 1'b0;
                end
                cfg_enable = data[0];
            end
            CFG_SENS:  cfg_sens  = data;
            CFG_QUIET: cfg_quiet = data[QUIET_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void detector_predict(input logic kind, input logic [ECHO_W-1:0] echo,
                                             input logic [TIME_W-1:0] now);
        t_reading          r;
        logic [ECHO_W-1:0] used_echo;
        logic [DIST_W-1:0] range_q8;
        logic [DIST_W-1:0] delta;
        logic [20:0]       blend;
        r = '0;
        if (kind == KIND_READ) begin
            r.flag      = motion_held;
            motion_held = 1'b0;
        end else begin
            used_echo = echo;
            if (echo == '0 || echo > ECHO_LIMIT_US) begin
                r.out_of_range = 1'b1;
                used_echo      = '0;
            end
            range_q8 = 18'((64'(used_echo) * SCALE_MULT + (64'd1 << 15)) >> 16);
            r.distance = range_q8;
            if (cfg_enable) begin
                if (warmup_count < WARMUP_SAMPLES) begin
                    warmup_sum   = warmup_sum + 20'(range_q8);
                    warmup_count = warmup_count + 1'b1;
                    if (warmup_count >= WARMUP_SAMPLES) begin
                        base_q8      = 18'((warmup_sum + WARMUP_SAMPLES / 2) / WARMUP_SAMPLES);
                        last_move_ms = now;
                        motion_held  = 1'b0;
                    end
                end else if (!r.out_of_range) begin
                    delta = (range_q8 >= base_q8) ? range_q8 - base_q8 : base_q8 - range_q8;
                    if (delta >= cfg_sens) begin
                        r.rise       = !motion_held;
                        motion_held  = 1'b1;
                        last_move_ms = now;
                    end else begin
                        motion_held = 1'b0;
                        if (32'(now - last_move_ms) >= 32'(cfg_quiet)) begin
                            blend        = {1'b0, base_q8, 2'b00} + 21'(range_q8) + 21'd2;
                            base_q8      = 18'(blend / 5);
                            last_move_ms = now;
                        end
                    end
                end
            end
            r.flag = motion_held;
        end
        r.base_ready = warmup_count >= WARMUP_SAMPLES;
        r.baseline   = base_q8;
        expected_readings.push_back(r);
    endfunction

    // echo length whose distance lands near dist_q8, kept inside the valid range
    function automatic logic [ECHO_W-1:0] echo_for(input logic [DIST_W-1:0] dist_q8);
        longint e;
        e = (longint'(dist_q8) * 65536) / SCALE_MULT;
        if (e < 1) e = 1;
        if (e > ECHO_LIMIT_US) e = ECHO_LIMIT_US;
        return 16'(e);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got %0d want %0d", $realtime, field, got, want);
        mismatch_count++;
    endtask

    task automatic send_word(input logic kind, input logic [ECHO_W-1:0] echo,
                             input logic [TIME_W-1:0] now);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_echo_us <= echo;
        i_now_ms  <= now;
        do @(posedge i_clk); while (!o_ready);
        detector_predict(kind, echo, now);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        detector_configure(idx, data);
    endtask

    // unused data bits are randomised; the spare index must be ignored
    task automatic configure(input logic en, input logic [DIST_W-1:0] sens,
                             input logic [QUIET_W-1:0] quiet);
        wait_idle();
        cfg_write(CFG_SPARE, 18'($urandom));
        cfg_write(CFG_SENS, sens);
        cfg_write(CFG_QUIET, {2'($urandom), quiet});
        cfg_write(CFG_ENABLE, {17'($urandom), en});
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : result_sink
        int stall;
        forever begin
            stall = $urandom_range(0, gap_max);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_reading want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("word with nothing expected, distance", o_distance_q8, 0);
            end else begin
                want = expected_readings.pop_front();
                if (o_distance_q8 !== want.distance)
                    report_mismatch("distance_q8", o_distance_q8, want.distance);
                if (o_out_of_range !== want.out_of_range)
                    report_mismatch("out_of_range", o_out_of_range, want.out_of_range);
                if (o_baseline_ready !== want.base_ready)
                    report_mismatch("baseline_ready", o_baseline_ready, want.base_ready);
                if (o_baseline_q8 !== want.baseline)
                    report_mismatch("baseline_q8", o_baseline_q8, want.baseline);
                if (o_motion_flag !== want.flag)
                    report_mismatch("motion_flag", o_motion_flag, want.flag);
                if (o_motion_event !== want.rise)
                    report_mismatch("motion_event", o_motion_event, want.rise);
            end
        end
    end

    task automatic test_disabled_after_reset();
        send_word(KIND_MEAS, 16'd0, 32'd0);
        send_word(KIND_MEAS, 16'd1, 32'hFFFF_FFFF);
        send_word(KIND_MEAS, 16'(ECHO_LIMIT_US), 32'd5);
        send_word(KIND_MEAS, 16'(ECHO_LIMIT_US + 1), 32'd6);
        send_word(KIND_MEAS, 16'hFFFF, 32'd7);
        send_word(KIND_READ, 16'hFFFF, 32'd8);
    endtask

    // timeouts enter the average as zero
    task automatic test_baseline_average();
        configure(1'b1, SENS_RESET, QUIET_RESET);
        send_word(KIND_MEAS, 16'd0, 32'd100);
        send_word(KIND_MEAS, 16'd10000, 32'd101);
        send_word(KIND_MEAS, 16'd12345, 32'd102);
        send_word(KIND_MEAS, 16'(ECHO_LIMIT_US), 32'd103);
        send_word(KIND_MEAS, 16'd40000, 32'd104);
        send_word(KIND_READ, 16'd0, 32'd105);
    endtask

    task automatic test_motion_and_adapt();
        send_word(KIND_MEAS, echo_for(base_q8 + 18'd5000), 32'd200);
        send_word(KIND_MEAS, echo_for(base_q8 + 18'd5000), 32'd300);
        send_word(KIND_READ, 16'd0, 32'd301);
        send_word(KIND_MEAS, 16'd0, 32'd5000);
        send_word(KIND_MEAS, echo_for(base_q8 + 18'd100), 32'd1300);
    endtask

    task automatic test_timestamp_wrap();
        send_word(KIND_MEAS, echo_for(base_q8 + 18'd9000), 32'hFFFF_FF00);
        send_word(KIND_MEAS, echo_for(base_q8), 32'h0000_0300);
    endtask

    task automatic test_sensitivity_extremes();
        configure(1'b1, '1, '0);
        send_word(KIND_MEAS, 16'(ECHO_LIMIT_US), 32'h0000_0400);
        configure(1'b1, '0, '0);
        send_word(KIND_MEAS, echo_for(base_q8), 32'h0000_0401);
        send_word(KIND_MEAS, 16'hFFFF, 32'h0000_0402);
    endtask

    task automatic test_disable_and_restart();
        configure(1'b0, SENS_RESET, QUIET_RESET);
        send_word(KIND_MEAS, 16'd20000, 32'h0000_0500);
        send_word(KIND_READ, 16'd0, 32'h0000_0501);
        configure(1'b1, SENS_RESET, QUIET_RESET);
        send_word(KIND_MEAS, 16'd100, 32'h0000_0502);
    endtask

    // mostly echoes around the baseline, spread to about the sensitivity on either side
    task automatic test_random_traffic();
        logic [DIST_W-1:0]  sens;
        logic [QUIET_W-1:0] quiet;
        logic [TIME_W-1:0]  clock_ms;
        int                 roll;
        int                 span;
        int                 echo_c;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 4))
                0:       sens = '0;
                1:       sens = '1;
                2:       sens = 18'(DIST_MAX);
                default: sens = 18'($urandom_range(0, 4000));
            endcase
            case ($urandom_range(0, 3))
                0:       quiet = '0;
                1:       quiet = '1;
                default: quiet = 16'($urandom_range(0, 3000));
            endcase
            configure($urandom_range(0, 5) != 0, sens, quiet);
            if ($urandom_range(0, 2) == 0)
                clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 20000));
            else
                clock_ms = $urandom;
            for (int n = 0; n < 100; n++) begin
                if (n % 25 == 0)
                    gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
                if ($urandom_range(0, 199) == 0)
                    wait_idle();
                clock_ms = clock_ms + $urandom_range(0, int'(quiet) / 3 + 50);
                roll = $urandom_range(0, 19);
                if (roll < 2) begin
                    send_word(KIND_READ, 16'($urandom), clock_ms);
                end else if (roll == 2) begin
                    if ($urandom_range(0, 1) == 0)
                        send_word(KIND_MEAS, 16'd0, clock_ms);
                    else
                        send_word(KIND_MEAS, 16'($urandom_range(ECHO_LIMIT_US + 1, 65535)),
                                  clock_ms);
                end else if (roll == 3) begin
                    send_word(KIND_MEAS, 16'($urandom), clock_ms);
                end else if (warmup_count < WARMUP_SAMPLES) begin
                    send_word(KIND_MEAS, 16'($urandom_range(1, ECHO_LIMIT_US)), clock_ms);
                end else begin
                    span   = int'(cfg_sens) * 2 / 9 + 2;
                    echo_c = int'(echo_for(base_q8)) - span + $urandom_range(0, 2 * span);
                    if (echo_c < 1) echo_c = 1;
                    if (echo_c > ECHO_LIMIT_US) echo_c = ECHO_LIMIT_US;
                    send_word(KIND_MEAS, 16'(echo_c), clock_ms);
                end
            end
        end
        gap_max = 12;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled_after_reset();
        test_baseline_average();
        test_motion_and_adapt();
        test_timestamp_wrap();
        test_sensitivity_extremes();
        test_disable_and_restart();
        test_random_traffic();
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
